// ===== design/efd_pkg.sv =====
// Shared types and constants for the escaped frame decoder.
// Used by efd_decode, efd_out_buf and escaped_frame_decoder; depends on nothing.
package efd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 3;
    localparam int KIND_W     = 2;
    localparam int TDATA_W    = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_SOF_CODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_CODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_ALT_CODE = 2'd2;

    localparam logic [BYTE_W-1:0] SOF_CODE_RST     = 8'd255;
    localparam logic [BYTE_W-1:0] ESC_CODE_RST     = 8'd254;
    localparam logic [BYTE_W-1:0] ESC_ALT_CODE_RST = 8'd253;
    localparam logic [BYTE_W-1:0] HEADER_BYTES     = 8'd4;

    localparam logic [POS_W-1:0] POS_IDLE    = 3'd0;
    localparam logic [POS_W-1:0] POS_LEN     = 3'd1;
    localparam logic [POS_W-1:0] POS_ID0     = 3'd2;
    localparam logic [POS_W-1:0] POS_ID1     = 3'd3;
    localparam logic [POS_W-1:0] POS_MANUF   = 3'd4;
    localparam logic [POS_W-1:0] POS_TYPE    = 3'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 3'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        last;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [7:0]  pay_size;
        logic [7:0]  dev_model;
        logic [7:0]  manufacturer;
        logic [5:0]  cmd_class;
        logic [3:0]  cmd_index;
        logic [5:0]  device;
    } t_result;

endpackage

// ===== design/efd_decode.sv =====
// Frame parser and unescaper: configuration registers, frame state and the
// per-byte result logic. Depends on efd_pkg.
module efd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [efd_pkg::BYTE_W-1:0]    i_enc_byte,
    input  logic                          i_frame_start,
    input  logic                          i_cfg_we,
    input  logic [efd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [efd_pkg::BYTE_W-1:0]    i_cfg_data,
    output logic                          o_res_valid,
    output efd_pkg::t_result              o_res
);
    import efd_pkg::*;

    logic [BYTE_W-1:0] r_sof_code, r_esc_code, r_esc_alt_code;
    logic [POS_W-1:0]  r_byte_pos, n_byte_pos;
    logic              r_escape_pending, n_escape_pending;
    logic              r_frame_done, n_frame_done;
    logic [BYTE_W-1:0] r_data_count, n_data_count;
    logic [BYTE_W-1:0] r_payload_len, n_payload_len;
    logic [5:0]        r_hold_device, n_hold_device;
    logic [3:0]        r_hold_cmd_index, n_hold_cmd_index;
    logic [5:0]        r_hold_cmd_class, n_hold_cmd_class;
    logic [7:0]        r_hold_manufacturer, n_hold_manufacturer;
    logic [BYTE_W-1:0] count_inc;
    logic [BYTE_W-1:0] value;
    logic              emit_data;
    logic              data_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof_code     <= SOF_CODE_RST;
            r_esc_code     <= ESC_CODE_RST;
            r_esc_alt_code <= ESC_ALT_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOF_CODE:     r_sof_code     <= i_cfg_data;
                CFG_ESC_CODE:     r_esc_code     <= i_cfg_data;
                CFG_ESC_ALT_CODE: r_esc_alt_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos          <= POS_IDLE;
            r_escape_pending    <= 1'b0;
            r_frame_done        <= 1'b1;
            r_data_count        <= '0;
            r_payload_len       <= '0;
            r_hold_device       <= '0;
            r_hold_cmd_index    <= '0;
            r_hold_cmd_class    <= '0;
            r_hold_manufacturer <= '0;
        end else if (i_accept) begin
            r_byte_pos          <= n_byte_pos;
            r_escape_pending    <= n_escape_pending;
            r_frame_done        <= n_frame_done;
            r_data_count        <= n_data_count;
            r_payload_len       <= n_payload_len;
            r_hold_device       <= n_hold_device;
            r_hold_cmd_index    <= n_hold_cmd_index;
            r_hold_cmd_class    <= n_hold_cmd_class;
            r_hold_manufacturer <= n_hold_manufacturer;
        end
    end

    assign count_inc = r_data_count + 8'd1;
    assign data_last = (count_inc == r_payload_len);

    always_comb begin
        n_byte_pos          = r_byte_pos;
        n_escape_pending    = r_escape_pending;
        n_frame_done        = r_frame_done;
        n_data_count        = r_data_count;
        n_payload_len       = r_payload_len;
        n_hold_device       = r_hold_device;
        n_hold_cmd_index    = r_hold_cmd_index;
        n_hold_cmd_class    = r_hold_cmd_class;
        n_hold_manufacturer = r_hold_manufacturer;
        o_res_valid         = 1'b0;
        o_res               = '0;
        o_res.pay_size      = r_payload_len;
        value               = i_enc_byte;
        emit_data           = 1'b0;

        if (i_frame_start) begin
            n_byte_pos       = POS_LEN;
            n_escape_pending = 1'b0;
            n_frame_done     = 1'b0;
            n_data_count     = '0;
        end else if (!r_frame_done) begin
            case (r_byte_pos)
                POS_LEN: begin
                    n_payload_len = i_enc_byte - HEADER_BYTES;
                    n_byte_pos    = POS_ID0;
                end
                POS_ID0: begin
                    n_hold_device    = i_enc_byte[5:0];
                    n_hold_cmd_index = {2'b00, i_enc_byte[7:6]};
                    n_byte_pos       = POS_ID1;
                end
                POS_ID1: begin
                    n_hold_cmd_index = {i_enc_byte[1:0], r_hold_cmd_index[1:0]};
                    n_hold_cmd_class = i_enc_byte[7:2];
                    n_byte_pos       = POS_MANUF;
                end
                POS_MANUF: begin
                    n_hold_manufacturer = i_enc_byte;
                    n_byte_pos          = POS_TYPE;
                end
                POS_TYPE: begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_HEADER;
                    o_res.device       = r_hold_device;
                    o_res.cmd_index    = r_hold_cmd_index;
                    o_res.cmd_class    = r_hold_cmd_class;
                    o_res.manufacturer = r_hold_manufacturer;
                    o_res.dev_model    = i_enc_byte;
                    o_res.last         = (r_payload_len == '0);
                    n_byte_pos         = POS_PAYLOAD;
                    n_frame_done       = (r_payload_len == '0);
                end
                default: begin
                    if (r_escape_pending) begin
                        n_escape_pending = 1'b0;
                        if (i_enc_byte == r_esc_code) begin
                            value     = r_sof_code;
                            emit_data = 1'b1;
                        end else if (i_enc_byte == r_esc_alt_code) begin
                            value     = r_esc_code;
                            emit_data = 1'b1;
                        end else begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = KIND_ERROR;
                            o_res.data_index = r_data_count;
                            o_res.last       = 1'b1;
                            n_frame_done     = 1'b1;
                        end
                    end else if (i_enc_byte == r_esc_code) begin
                        n_escape_pending = 1'b1;
                    end else begin
                        emit_data = 1'b1;
                    end
                    if (emit_data) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_DATA;
                        o_res.data_index = r_data_count;
                        o_res.data_byte  = value;
                        o_res.last       = data_last;
                        n_data_count     = count_inc;
                        n_frame_done     = data_last;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/efd_out_buf.sv =====
// Two-entry result buffer that decouples the decoder from a stalling receiver.
// Depends on efd_pkg for the result type.
module efd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  efd_pkg::t_result i_data,
    output logic             o_not_full,
    output logic             o_valid,
    output efd_pkg::t_result o_data,
    input  logic             i_ready
);
    import efd_pkg::*;

    t_result     r_entry [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        pop;

    assign o_valid    = (r_count != 2'd0);
    assign o_not_full = (r_count != 2'd2);
    assign o_data     = r_entry[r_rd_ptr];
    assign pop        = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/escaped_frame_decoder.sv =====
// Top level of the escaped frame decoder.
// Instantiates efd_decode and efd_out_buf; depends on efd_pkg.
//
// Usage: encoded frame bytes enter on the slave stream, one byte per request,
// with tuser set on the start byte of each frame. The header result is sent
// on the fourth identifier byte, then one result per decoded payload byte,
// or one error result on a bad escape follower. tuser of the master stream
// gives the result kind and tlast marks the final result of a frame.
// The configuration channel is always ready and sets the start, escape and
// alternate codes; write it only while no frame is in flight.
// Each accepted byte's result is registered in the output buffer before it reaches the master side.
// Throughput is one byte per cycle while the output buffer has room.
// Results sit in a two-entry buffer; while the receiver stalls, the slave side
// keeps taking bytes until both entries are full, then drops tready.
// After reset the codes return to 255, 254 and 253, the buffer is empty and
// the decoder ignores bytes until a start byte arrives.
module escaped_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // enc_byte
    input  logic                          i_s_tuser,   // frame_start
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // device, cmd_index, cmd_class, manufacturer, dev_model, pay_size,
    // data_index, data_byte
    output logic [efd_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [efd_pkg::KIND_W-1:0]    o_m_tuser,   // kind
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [efd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [efd_pkg::BYTE_W-1:0]    i_cfg_data
);
    import efd_pkg::*;

    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    buf_not_full;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = buf_not_full;
    assign in_accept   = i_s_tvalid && buf_not_full;

    efd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_enc_byte    (i_s_tdata),
        .i_frame_start (i_s_tuser),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    efd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_accept && res_valid),
        .i_data     (res),
        .o_not_full (buf_not_full),
        .o_valid    (o_m_tvalid),
        .o_data     (out_res),
        .i_ready    (i_m_tready)
    );

    assign o_m_tdata = {out_res.data_byte, out_res.data_index, out_res.pay_size,
                        out_res.dev_model, out_res.manufacturer, out_res.cmd_class,
                        out_res.cmd_index, out_res.device};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last;

endmodule
